// ----- rtl/ptsb_pkg.sv -----
// Shared types, codes and constants for the periodic timer slot bank.
package ptsb_pkg;

    localparam int DEF_NUM_SLOTS  = 8;
    localparam int DEF_COUNT_BITS = 16;
    localparam int PERIOD_BITS    = 16;
    localparam int SLOT_BITS      = 3;
    localparam int MAX_OUT        = 8;
    localparam int NUM_OUT_BITS   = $clog2(MAX_OUT + 1);

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_SCAN     = 2'd2,
        ACT_COMPLETE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_TICKED    = 3'd2,
        ST_EXPIRED   = 3'd3,
        ST_NONE      = 3'd4,
        ST_COMPLETED = 3'd5,
        ST_IGNORED   = 3'd6
    } status_t;

    typedef struct packed {
        logic                    valid;
        action_t                 action;
        logic [PERIOD_BITS-1:0]  period;
        logic [SLOT_BITS-1:0]    sel;
        logic                    keep;
        logic                    hit;
        logic [SLOT_BITS-1:0]    slot;
        logic                    pend_valid;
        logic [SLOT_BITS-1:0]    pend_slot;
        logic [NUM_OUT_BITS-1:0] num_out;
    } wave_t;

    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [SLOT_BITS-1:0] slot;
        logic                 last;
    } result_t;

endpackage

// ----- rtl/ptsb_cell.sv -----
// One timer slot of the bank and its stage of the command wave.
module ptsb_cell
    import ptsb_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int IDX        = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  wave_t   wave_in,
    output wave_t   wave_out,
    output result_t emit
);

    localparam logic [SLOT_BITS-1:0] SLOT_ID = SLOT_BITS'(IDX);
    localparam bit SEL_REACH = (IDX < (1 << SLOT_BITS));

    logic                  en_reg, en_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] rld_reg, rld_next;
    wave_t                 wave_reg, wave_next;
    logic [COUNT_BITS-1:0] period_c;
    logic                  expired;

    assign period_c = COUNT_BITS'(wave_in.period);
    assign expired  = en_reg && (cnt_reg == '0);

    always_comb
    begin
        en_next   = en_reg;
        cnt_next  = cnt_reg;
        rld_next  = rld_reg;
        wave_next = wave_in;
        emit      = '0;
        if (wave_in.valid)
        begin
            case (wave_in.action)
                ACT_INSERT:
                begin
                    if (!wave_in.hit && !en_reg)
                    begin
                        en_next        = 1'b1;
                        cnt_next       = period_c;
                        rld_next       = period_c;
                        wave_next.hit  = 1'b1;
                        wave_next.slot = SLOT_ID;
                    end
                end
                ACT_TICK:
                begin
                    if (en_reg && (cnt_reg != '0))
                    begin
                        cnt_next = cnt_reg - COUNT_BITS'(1);
                    end
                end
                ACT_SCAN:
                begin
                    if (expired && (wave_in.num_out < NUM_OUT_BITS'(MAX_OUT)))
                    begin
                        if (wave_in.pend_valid)
                        begin
                            emit.valid  = 1'b1;
                            emit.status = ST_EXPIRED;
                            emit.slot   = wave_in.pend_slot;
                            emit.last   = 1'b0;
                        end
                        wave_next.pend_valid = 1'b1;
                        wave_next.pend_slot  = SLOT_ID;
                        wave_next.num_out    = wave_in.num_out + NUM_OUT_BITS'(1);
                    end
                end
                ACT_COMPLETE:
                begin
                    if (SEL_REACH && (wave_in.sel == SLOT_ID) && expired)
                    begin
                        if (wave_in.keep)
                        begin
                            cnt_next = rld_reg;
                        end
                        else
                        begin
                            en_next = 1'b0;
                        end
                        wave_next.hit  = 1'b1;
                        wave_next.slot = SLOT_ID;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= 1'b0;
            cnt_reg  <= '0;
            rld_reg  <= '0;
            wave_reg <= '0;
        end
        else
        begin
            en_reg   <= en_next;
            cnt_reg  <= cnt_next;
            rld_reg  <= rld_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

// ----- rtl/periodic_timer_slot_bank.sv -----
// Top level of the periodic timer slot bank: command intake, slot chain and result register.
//
// Usage: raise start with action, period, slot_sel and keep; the command is
// transferred at a rising edge where start is high and busy is low. busy then
// stays high until the command's last result has been shown.
// The command travels down a chain of NUM_SLOTS slot cells, one cell per
// cycle; each cell updates its own slot as the command passes.
// Results appear on status, slot_num and last for exactly one cycle each,
// marked by valid. Every command gives one result, except scan, which gives
// one result per expired slot (at most eight, lowest slot first) or a single
// "none expired" result. last marks the final result of a command.
// The command passes the NUM_SLOTS cell registers and then the result register
// before its final result is shown; busy drops with it, so a new command is
// taken only after the previous command's final result. A scan result for
// slot k is shown only after the command has passed cell k.
// Reset clears every slot (disabled, zero count and reload) and the chain.
// The receiver cannot stall: each result must be taken in the cycle it shows.
module periodic_timer_slot_bank
    import ptsb_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             action,
    input  logic [PERIOD_BITS-1:0] period,
    input  logic [SLOT_BITS-1:0]   slot_sel,
    input  logic                   keep,
    output logic                   valid,
    output logic [2:0]             status,
    output logic [SLOT_BITS-1:0]   slot_num,
    output logic                   last
);

    wave_t   chain [0:NUM_SLOTS];
    result_t cell_emit [0:NUM_SLOTS-1];
    logic [NUM_SLOTS-1:0] emit_vec;
    result_t emit_any;
    result_t final_res;
    wave_t   tail;
    logic    accept;

    logic                 busy_reg, busy_next;
    logic                 valid_reg, valid_next;
    status_t              status_reg, status_next;
    logic [SLOT_BITS-1:0] slot_num_reg, slot_num_next;
    logic                 last_reg, last_next;

    assign accept = start && !busy_reg;

    always_comb
    begin
        chain[0]        = '0;
        chain[0].valid  = accept;
        chain[0].action = action_t'(action);
        chain[0].period = period;
        chain[0].sel    = slot_sel;
        chain[0].keep   = keep;
    end

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        ptsb_cell #(
            .COUNT_BITS(COUNT_BITS),
            .IDX       (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wave_in (chain[i]),
            .wave_out(chain[i+1]),
            .emit    (cell_emit[i])
        );
        assign emit_vec[i] = cell_emit[i].valid;
    end

    assign tail = chain[NUM_SLOTS];

    always_comb
    begin
        emit_any = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            emit_any = result_t'(emit_any | cell_emit[i]);
        end
    end

    always_comb
    begin
        final_res       = '0;
        final_res.valid = tail.valid;
        final_res.last  = 1'b1;
        case (tail.action)
            ACT_INSERT:
            begin
                final_res.status = tail.hit ? ST_INSERTED : ST_FULL;
                final_res.slot   = tail.hit ? tail.slot : '0;
            end
            ACT_TICK:
            begin
                final_res.status = ST_TICKED;
            end
            ACT_SCAN:
            begin
                final_res.status = tail.pend_valid ? ST_EXPIRED : ST_NONE;
                final_res.slot   = tail.pend_valid ? tail.pend_slot : '0;
            end
            ACT_COMPLETE:
            begin
                final_res.status = tail.hit ? ST_COMPLETED : ST_IGNORED;
                final_res.slot   = tail.hit ? tail.slot : '0;
            end
            default:
            begin
                final_res.status = ST_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        busy_next     = busy_reg;
        valid_next    = 1'b0;
        status_next   = status_reg;
        slot_num_next = slot_num_reg;
        last_next     = last_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (emit_any.valid)
        begin
            valid_next    = 1'b1;
            status_next   = emit_any.status;
            slot_num_next = emit_any.slot;
            last_next     = 1'b0;
        end
        else if (final_res.valid)
        begin
            valid_next    = 1'b1;
            status_next   = final_res.status;
            slot_num_next = final_res.slot;
            last_next     = 1'b1;
            busy_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            status_reg   <= ST_INSERTED;
            slot_num_reg <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            valid_reg    <= valid_next;
            status_reg   <= status_next;
            slot_num_reg <= slot_num_next;
            last_reg     <= last_next;
        end
    end

    assign busy     = busy_reg;
    assign valid    = valid_reg;
    assign status   = status_reg;
    assign slot_num = slot_num_reg;
    assign last     = last_reg;

    a_fall_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (valid_reg && last_reg))
        else $error("busy dropped without a final result");

    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> busy_reg)
        else $error("non-final result shown while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("transfer taken without raising busy");

    a_one_emitter: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(emit_vec) && !(emit_any.valid && final_res.valid))
        else $error("more than one result source in a cycle");

endmodule

// ----- sim/testbench.sv -----
// Testbench for the periodic timer slot bank: directed command table, then random commands, checked by table or slot bank model.
module testbench;
    import ptsb_pkg::*;

    localparam int N_SLOTS    = DEF_NUM_SLOTS;
    localparam int CNT_BITS   = DEF_COUNT_BITS;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 85;

    typedef struct packed {
        status_t              status;
        logic [SLOT_BITS-1:0] slot;
        logic                 last;
    } timer_res_t;

    typedef struct packed {
        action_t                act;
        logic [PERIOD_BITS-1:0] period;
        logic [SLOT_BITS-1:0]   sel;
        logic                   keep;
        logic                   fixed;
        status_t                status;
        logic [SLOT_BITS-1:0]   slot;
    } timer_cmd_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   start    = 1'b0;
    logic [1:0]             action   = ACT_INSERT;
    logic [PERIOD_BITS-1:0] period   = '0;
    logic [SLOT_BITS-1:0]   slot_sel = '0;
    logic                   keep     = 1'b0;
    logic                   busy;
    logic                   valid;
    logic [2:0]             status;
    logic [SLOT_BITS-1:0]   slot_num;
    logic                   last;

    logic                slot_on  [N_SLOTS];
    logic [CNT_BITS-1:0] slot_cnt [N_SLOTS];
    logic [CNT_BITS-1:0] slot_per [N_SLOTS];

    timer_res_t pending_results[$];
    timer_res_t bank_results[$];
    timer_cmd_t directed_cmds [N_DIRECTED];
    int         mismatches = 0;
    int         burst_left = 0;
    logic       drain_hold = 1'b0;

    periodic_timer_slot_bank uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .period   (period),
        .slot_sel (slot_sel),
        .keep     (keep),
        .valid    (valid),
        .status   (status),
        .slot_num (slot_num),
        .last     (last)
    );

    always #10 clk = ~clk;

    function automatic timer_res_t mk_res(status_t st, int slot, logic lst);
        timer_res_t r;
        r.status = st;
        r.slot   = slot[SLOT_BITS-1:0];
        r.last   = lst;
        return r;
    endfunction

    function void advance_slot_bank(timer_cmd_t c);
        int   i;
        logic done;
        logic [CNT_BITS-1:0] p;
        p    = c.period[CNT_BITS-1:0];
        done = 1'b0;
        bank_results.delete();
        case (c.act)
            ACT_INSERT:
            begin
                for (i = 0; i < N_SLOTS; i++)
                begin
                    if (!done && !slot_on[i])
                    begin
                        slot_on[i]  = 1'b1;
                        slot_cnt[i] = p;
                        slot_per[i] = p;
                        bank_results.push_back(mk_res(ST_INSERTED, i, 1'b1));
                        done = 1'b1;
                    end
                end
                if (!done)
                    bank_results.push_back(mk_res(ST_FULL, 0, 1'b1));
            end
            ACT_TICK:
            begin
                for (i = 0; i < N_SLOTS; i++)
                    if (slot_on[i] && slot_cnt[i] != '0)
                        slot_cnt[i] = slot_cnt[i] - 1'b1;
                bank_results.push_back(mk_res(ST_TICKED, 0, 1'b1));
            end
            ACT_SCAN:
            begin
                for (i = 0; i < N_SLOTS; i++)
                    if (slot_on[i] && slot_cnt[i] == '0 && bank_results.size() < MAX_OUT)
                        bank_results.push_back(mk_res(ST_EXPIRED, i, 1'b0));
                if (bank_results.size() == 0)
                    bank_results.push_back(mk_res(ST_NONE, 0, 1'b1));
                else
                    bank_results[bank_results.size()-1].last = 1'b1;
            end
            default:
            begin
                if (c.sel < N_SLOTS && slot_on[c.sel] && slot_cnt[c.sel] == '0)
                begin
                    if (c.keep)
                        slot_cnt[c.sel] = slot_per[c.sel];
                    else
                        slot_on[c.sel] = 1'b0;
                    bank_results.push_back(mk_res(ST_COMPLETED, c.sel, 1'b1));
                end
                else
                    bank_results.push_back(mk_res(ST_IGNORED, 0, 1'b1));
            end
        endcase
    endfunction

    function automatic timer_cmd_t make_random_cmd();
        timer_cmd_t c;
        int         pick;
        int         expired[$];
        int         i;
        c    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c.act = ACT_INSERT;
        else if (pick < 55)
            c.act = ACT_TICK;
        else if (pick < 75)
            c.act = ACT_SCAN;
        else
            c.act = ACT_COMPLETE;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            c.period = PERIOD_BITS'($urandom_range(0, 4));
        else if (pick < 8)
            c.period = PERIOD_BITS'($urandom_range(0, 20));
        else if (pick == 8)
            c.period = PERIOD_BITS'($urandom);
        else
            c.period = $urandom_range(0, 1) ? '1 : '0;
        c.sel  = SLOT_BITS'($urandom_range(0, N_SLOTS - 1));
        c.keep = 1'($urandom_range(0, 1));
        if (c.act == ACT_COMPLETE && $urandom_range(0, 9) < 8)
        begin
            for (i = 0; i < N_SLOTS; i++)
                if (slot_on[i] && slot_cnt[i] == '0)
                    expired.push_back(i);
            if (expired.size() > 0)
                c.sel = SLOT_BITS'(expired[$urandom_range(0, expired.size() - 1)]);
        end
        return c;
    endfunction

    task send_cmd(input timer_cmd_t c);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(4, 10);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 12);
        if (drain_hold && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain_hold && pending_results.size() != 0)
                @(posedge clk);
            drain_hold = 1'b0;
        end
        start    <= 1'b1;
        action   <= c.act;
        period   <= c.period;
        slot_sel <= c.sel;
        keep     <= c.keep;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        advance_slot_bank(c);
        if (c.fixed)
            pending_results.push_back(mk_res(c.status, c.slot, 1'b1));
        else
            foreach (bank_results[k])
                pending_results.push_back(bank_results[k]);
    endtask

    task note_mismatch(input string what, input timer_res_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch, %s: expected status %0d slot %0d last %0d, got %0d %0d %0d",
                     what, want.status, want.slot, want.last, status, slot_num, last);
    endtask

    always @(posedge clk)
    begin : result_check
        timer_res_t want;
        if (rst_n && valid !== 1'b0)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected transfer", '0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || slot_num !== want.slot || last !== want.last)
                    note_mismatch("field", want);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        for (i = 0; i < N_SLOTS; i++)
        begin
            slot_on[i]  = 1'b0;
            slot_cnt[i] = '0;
            slot_per[i] = '0;
        end
        directed_cmds[0]  = '{ACT_SCAN,     16'd0,     3'd0, 1'b0, 1'b1, ST_NONE,      3'd0};
        directed_cmds[1]  = '{ACT_COMPLETE, 16'd0,     3'd0, 1'b1, 1'b1, ST_IGNORED,   3'd0};
        directed_cmds[2]  = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd0};
        directed_cmds[3]  = '{ACT_INSERT,   16'd1,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd1};
        directed_cmds[4]  = '{ACT_INSERT,   16'd2,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd2};
        directed_cmds[5]  = '{ACT_SCAN,     16'd0,     3'd0, 1'b0, 1'b0, ST_INSERTED,  3'd0};
        directed_cmds[6]  = '{ACT_COMPLETE, 16'd0,     3'd0, 1'b1, 1'b1, ST_COMPLETED, 3'd0};
        directed_cmds[7]  = '{ACT_SCAN,     16'd0,     3'd0, 1'b0, 1'b0, ST_INSERTED,  3'd0};
        directed_cmds[8]  = '{ACT_COMPLETE, 16'd0,     3'd1, 1'b1, 1'b1, ST_IGNORED,   3'd0};
        directed_cmds[9]  = '{ACT_TICK,     16'd0,     3'd0, 1'b0, 1'b1, ST_TICKED,    3'd0};
        directed_cmds[10] = '{ACT_SCAN,     16'd0,     3'd0, 1'b0, 1'b0, ST_INSERTED,  3'd0};
        directed_cmds[11] = '{ACT_COMPLETE, 16'd0,     3'd1, 1'b0, 1'b1, ST_COMPLETED, 3'd1};
        directed_cmds[12] = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd1};
        directed_cmds[13] = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd3};
        directed_cmds[14] = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd4};
        directed_cmds[15] = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd5};
        directed_cmds[16] = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd6};
        directed_cmds[17] = '{ACT_INSERT,   16'd0,     3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd7};
        directed_cmds[18] = '{ACT_INSERT,   16'd5,     3'd0, 1'b0, 1'b1, ST_FULL,      3'd0};
        directed_cmds[19] = '{ACT_TICK,     16'd0,     3'd0, 1'b0, 1'b1, ST_TICKED,    3'd0};
        directed_cmds[20] = '{ACT_SCAN,     16'd0,     3'd0, 1'b0, 1'b0, ST_INSERTED,  3'd0};
        directed_cmds[21] = '{ACT_COMPLETE, 16'd0,     3'd7, 1'b0, 1'b1, ST_COMPLETED, 3'd7};
        directed_cmds[22] = '{ACT_INSERT,   16'hFFFF,  3'd0, 1'b0, 1'b1, ST_INSERTED,  3'd7};
        directed_cmds[23] = '{ACT_COMPLETE, 16'd0,     3'd7, 1'b1, 1'b1, ST_IGNORED,   3'd0};
        directed_cmds[24] = '{ACT_TICK,     16'd0,     3'd0, 1'b0, 1'b1, ST_TICKED,    3'd0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_cmd(directed_cmds[i]);

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2 || $urandom_range(0, 29) == 0)
                drain_hold = 1'b1;
            send_cmd(make_random_cmd());
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (N_SLOTS + 4) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
